### hw/rtl/ordered_value_list_table_macros.svh
// assertion macros shared by the ordered value list table rtl
// no dependencies; included by the modules that carry checks
`ifndef ORDERED_VALUE_LIST_TABLE_MACROS_SVH
`define ORDERED_VALUE_LIST_TABLE_MACROS_SVH

// condition must hold at every clock edge outside reset
`define OVLT_ASSERT_HOLD(name, ck, rst_n, cond, msg) \
	name: assert property (@(posedge ck) disable iff (!rst_n) (cond)) else $error(msg);

// antecedent implies consequent in the same cycle
`define OVLT_ASSERT_IMPLY(name, ck, rst_n, ante, cons, msg) \
	name: assert property (@(posedge ck) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

### hw/rtl/ovlt_pkg.sv
`timescale 1ns / 1ps
// shared types and constants for the ordered value list table
// no dependencies; imported by controller, datapath and top level
package ovlt_pkg;

	localparam int DEPTH       = 16;
	localparam int AW          = $clog2(DEPTH);
	localparam int CW          = $clog2(DEPTH + 1);
	localparam int DATA_W      = 32;
	localparam int IN_TDATA_W  = 72;
	localparam int OUT_TDATA_W = 48;

	typedef enum logic [2:0] {
		CMD_APPEND  = 3'd0,
		CMD_FIND    = 3'd1,
		CMD_REPLACE = 3'd2,
		CMD_DELETE  = 3'd3,
		CMD_CLEAR   = 3'd4,
		CMD_READ    = 3'd5
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_NOT_FOUND = 2'd1,
		ST_FULL      = 2'd2,
		ST_RANGE     = 2'd3
	} status_t;

	// controller to datapath commands
	typedef struct packed {
		logic load;
		logic res_zero;
		logic append;
		logic clear;
		logic scan_start;
		logic scan_step;
		logic hit;
		logic replace;
		logic miss;
		logic shift_start;
		logic shift_step;
		logic shift_end;
		logic read_issue;
		logic read_bad;
		logic read_capture;
		logic publish;
	} ctl_t;

	// datapath to controller status
	typedef struct packed {
		cmd_t cmd;
		logic full;
		logic idx_ok;
		logic hit;
		logic walk_end;
		logic out_free;
	} sts_t;

endpackage

### hw/rtl/ovlt_ram.sv
`timescale 1ns / 1ps
// generic single write port, single read port ram with registered read
// no dependencies
module ovlt_ram #(
	parameter int DATA_W = 32,
	parameter int WORDS  = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(WORDS)-1:0] waddr,
	input  logic [DATA_W-1:0]        wdata,
	input  logic [$clog2(WORDS)-1:0] raddr,
	output logic [DATA_W-1:0]        rdata
);

	logic [DATA_W-1:0] mem_q [WORDS];
	logic [DATA_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

### hw/rtl/ovlt_dp.sv
`timescale 1ns / 1ps
// datapath: item registers, entry ram, walk pointer, result and output registers
// depends on ovlt_pkg, ovlt_ram and the assertion macro header
`include "ordered_value_list_table_macros.svh"
module ovlt_dp (
	input  logic                          clk,
	input  logic                          arst_n,
	input  ovlt_pkg::ctl_t                ctl,
	output ovlt_pkg::sts_t                sts,
	input  logic [2:0]                    in_cmd,
	input  logic [ovlt_pkg::DATA_W-1:0]   in_key,
	input  logic [ovlt_pkg::DATA_W-1:0]   in_new_value,
	input  logic [3:0]                    in_index,
	input  logic                          out_ready,
	output logic                          out_valid,
	output logic                          out_found,
	output logic [3:0]                    out_position,
	output logic [ovlt_pkg::DATA_W-1:0]   out_read_value,
	output logic [4:0]                    out_entry_count,
	output logic [1:0]                    out_status
);
	import ovlt_pkg::*;

	cmd_t              cmd_q;
	logic [DATA_W-1:0] key_q;
	logic [DATA_W-1:0] nv_q;
	logic [3:0]        idx_q;
	logic [CW-1:0]     count_q;
	logic [CW-1:0]     ptr_q;
	logic              pend_q;
	logic [AW-1:0]     pend_idx_q;
	logic              found_q;
	logic [AW-1:0]     pos_q;
	logic [DATA_W-1:0] rval_q;
	status_t           status_q;
	logic              out_valid_q;
	logic              out_found_q;
	logic [3:0]        out_position_q;
	logic [DATA_W-1:0] out_read_value_q;
	logic [4:0]        out_entry_count_q;
	logic [1:0]        out_status_q;

	logic              ptr_lt;
	logic              full;
	logic [CW+3:0]     idx_w;
	logic [CW+3:0]     cnt_w;
	logic [AW+3:0]     idx_x;
	logic [AW+3:0]     pos_x;
	logic [CW+4:0]     cnt_x;
	logic              we;
	logic [AW-1:0]     waddr;
	logic [DATA_W-1:0] wdata;
	logic [AW-1:0]     raddr;
	logic [DATA_W-1:0] rdata;
	logic              shift_wr;
	logic              pend_in_list;
	logic              shift_ok;

	assign ptr_lt   = ptr_q < count_q;
	assign full     = count_q == CW'(DEPTH);
	assign idx_w    = {{CW{1'b0}}, idx_q};
	assign cnt_w    = {4'b0000, count_q};
	assign idx_x    = {{AW{1'b0}}, idx_q};
	assign pos_x    = {4'b0000, pos_q};
	assign cnt_x    = {5'b00000, count_q};
	assign shift_wr = ctl.shift_step && pend_q;

	assign pend_in_list = CW'(pend_idx_q) < count_q;
	assign shift_ok     = pend_in_list && (pend_idx_q != '0);

	assign sts.cmd      = cmd_q;
	assign sts.full     = full;
	assign sts.idx_ok   = idx_w < cnt_w;
	assign sts.hit      = pend_q && (rdata == key_q);
	assign sts.walk_end = !pend_q && !ptr_lt;
	assign sts.out_free = !out_valid_q || out_ready;

	// one write a cycle: append at the tail, replace at the hit, or a shift down
	always_comb begin
		we    = 1'b0;
		waddr = count_q[AW-1:0];
		wdata = key_q;
		if (ctl.append && !full) begin
			we = 1'b1;
		end else if (ctl.hit && ctl.replace) begin
			we    = 1'b1;
			waddr = pend_idx_q;
			wdata = nv_q;
		end else if (shift_wr) begin
			we    = 1'b1;
			waddr = pend_idx_q - AW'(1);
			wdata = rdata;
		end
	end

	assign raddr = ctl.read_issue ? idx_x[AW-1:0] : ptr_q[AW-1:0];

	ovlt_ram #(
		.DATA_W(DATA_W),
		.WORDS (DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(raddr),
		.rdata(rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			ptr_q       <= '0;
			pend_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (ctl.append && !full) begin
				count_q <= count_q + CW'(1);
			end else if (ctl.clear) begin
				count_q <= '0;
			end else if (ctl.shift_end) begin
				count_q <= count_q - CW'(1);
			end
			if (ctl.scan_start) begin
				ptr_q  <= '0;
				pend_q <= 1'b0;
			end else if (ctl.shift_start) begin
				ptr_q  <= CW'(pend_idx_q) + CW'(1);
				pend_q <= 1'b0;
			end else if (ctl.scan_step || ctl.shift_step) begin
				pend_q <= ptr_lt;
				if (ptr_lt) begin
					ptr_q <= ptr_q + CW'(1);
				end
			end
			if (ctl.publish) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			cmd_q <= cmd_t'(in_cmd);
			key_q <= in_key;
			nv_q  <= in_new_value;
			idx_q <= in_index;
		end
		if ((ctl.scan_step || ctl.shift_step) && ptr_lt) begin
			pend_idx_q <= ptr_q[AW-1:0];
		end
		if (ctl.res_zero) begin
			found_q <= 1'b0;
			pos_q   <= '0;
			rval_q  <= '0;
		end else if (ctl.hit) begin
			found_q <= 1'b1;
			pos_q   <= pend_idx_q;
		end else if (ctl.read_capture) begin
			found_q <= 1'b1;
			pos_q   <= idx_x[AW-1:0];
			rval_q  <= rdata;
		end
		// a zeroed result starts as ok unless the decode already knows better
		if (ctl.append && full) begin
			status_q <= ST_FULL;
		end else if (ctl.read_bad) begin
			status_q <= ST_RANGE;
		end else if (ctl.miss) begin
			status_q <= ST_NOT_FOUND;
		end else if (ctl.res_zero) begin
			status_q <= ST_OK;
		end
		if (ctl.publish) begin
			out_found_q       <= found_q;
			out_position_q    <= pos_x[3:0];
			out_read_value_q  <= rval_q;
			out_entry_count_q <= cnt_x[4:0];
			out_status_q      <= status_q;
		end
	end

	assign out_valid       = out_valid_q;
	assign out_found       = out_found_q;
	assign out_position    = out_position_q;
	assign out_read_value  = out_read_value_q;
	assign out_entry_count = out_entry_count_q;
	assign out_status      = out_status_q;

	`OVLT_ASSERT_HOLD(a_count_bound, clk, arst_n, count_q <= CW'(DEPTH), "count above depth")
	`OVLT_ASSERT_IMPLY(a_hit_in_list, clk, arst_n, ctl.hit, pend_in_list, "hit beyond count")
	`OVLT_ASSERT_IMPLY(a_shift_in_list, clk, arst_n, shift_wr, shift_ok, "shift outside list")
	`OVLT_ASSERT_IMPLY(a_publish_free, clk, arst_n, ctl.publish, sts.out_free, "result overwritten")

endmodule

### hw/rtl/ovlt_ctrl.sv
`timescale 1ns / 1ps
// controller: one-hot state machine sequencing each command through the datapath
// depends on ovlt_pkg
module ovlt_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  ovlt_pkg::sts_t sts,
	output ovlt_pkg::ctl_t ctl
);
	import ovlt_pkg::*;

	typedef enum logic [5:0] {
		S_IDLE   = 6'b000001,
		S_DECODE = 6'b000010,
		S_SCAN   = 6'b000100,
		S_SHIFT  = 6'b001000,
		S_READ   = 6'b010000,
		S_DONE   = 6'b100000
	} state_t;

	state_t state_q;
	state_t state_d;

	assign in_ready = state_q == S_IDLE;

	always_comb begin
		ctl     = '0;
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					ctl.load = 1'b1;
					state_d  = S_DECODE;
				end
			end
			S_DECODE: begin
				ctl.res_zero = 1'b1;
				case (sts.cmd)
					CMD_APPEND: begin
						ctl.append = 1'b1;
						state_d    = S_DONE;
					end
					CMD_CLEAR: begin
						ctl.clear = 1'b1;
						state_d   = S_DONE;
					end
					CMD_FIND, CMD_REPLACE, CMD_DELETE: begin
						ctl.scan_start = 1'b1;
						state_d        = S_SCAN;
					end
					CMD_READ: begin
						if (sts.idx_ok) begin
							ctl.read_issue = 1'b1;
							state_d        = S_READ;
						end else begin
							ctl.read_bad = 1'b1;
							state_d      = S_DONE;
						end
					end
					default: begin
						state_d = S_DONE;
					end
				endcase
			end
			S_SCAN: begin
				if (sts.hit) begin
					ctl.hit     = 1'b1;
					ctl.replace = sts.cmd == CMD_REPLACE;
					if (sts.cmd == CMD_DELETE) begin
						ctl.shift_start = 1'b1;
						state_d         = S_SHIFT;
					end else begin
						state_d = S_DONE;
					end
				end else if (sts.walk_end) begin
					ctl.miss = 1'b1;
					state_d  = S_DONE;
				end else begin
					ctl.scan_step = 1'b1;
				end
			end
			S_SHIFT: begin
				if (sts.walk_end) begin
					ctl.shift_end = 1'b1;
					state_d       = S_DONE;
				end else begin
					ctl.shift_step = 1'b1;
				end
			end
			S_READ: begin
				ctl.read_capture = 1'b1;
				state_d          = S_DONE;
			end
			S_DONE: begin
				if (sts.out_free) begin
					ctl.publish = 1'b1;
					state_d     = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

### hw/rtl/ordered_value_list_table.sv
`timescale 1ns / 1ps
// top level of the ordered value list table: stream ports, field unpacking
// depends on ovlt_pkg, ovlt_ctrl and ovlt_dp
//
// a bounded list of up to DEPTH signed 32-bit values in insertion order, held in
// a single-port-read ram and walked one entry per clock. each command item gives
// exactly one result item. append, clear and unused command codes go from the
// decode state straight to the done state; read at index passes through a read
// state between them. find and replace walk the list to a match or its end;
// delete walks to the match, then shifts each later entry down one place.
// one item is worked on at a time; the finished result sits in an output register
// so the next item can be taken while the result waits for m_tready. there is no
// clearing pass after reset: entries are only read below the count, so the ram
// needs no initial contents.
module ordered_value_list_table (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	// key [31:0], new_value [63:32], index [67:64], zero padding [71:68]
	input  logic [ovlt_pkg::IN_TDATA_W-1:0]     s_tdata,
	// cmd [2:0]
	input  logic [2:0]                          s_tuser,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// found [0], position [4:1], read_value [36:5], entry_count [41:37],
	// status [43:42], zero padding [47:44]
	output logic [ovlt_pkg::OUT_TDATA_W-1:0]    m_tdata
);
	import ovlt_pkg::*;

	ctl_t              ctl;
	sts_t              sts;
	logic              in_ready;
	logic              out_found;
	logic [3:0]        out_position;
	logic [DATA_W-1:0] out_read_value;
	logic [4:0]        out_entry_count;
	logic [1:0]        out_status;

	// the controller only takes an item while it sits idle
	ovlt_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(s_tvalid),
		.in_ready(in_ready),
		.sts     (sts),
		.ctl     (ctl)
	);

	// item fields go straight into the datapath, captured on the load command
	ovlt_dp u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.ctl            (ctl),
		.sts            (sts),
		.in_cmd         (s_tuser),
		.in_key         (s_tdata[31:0]),
		.in_new_value   (s_tdata[63:32]),
		.in_index       (s_tdata[67:64]),
		.out_ready      (m_tready),
		.out_valid      (m_tvalid),
		.out_found      (out_found),
		.out_position   (out_position),
		.out_read_value (out_read_value),
		.out_entry_count(out_entry_count),
		.out_status     (out_status)
	);

	assign s_tready = in_ready;

	// result item packed lowest field first
	assign m_tdata = {4'b0000, out_status, out_entry_count, out_read_value,
		out_position, out_found};

endmodule
